>>> rtl/bsr_pkg.sv
package bsr_pkg;

  localparam int TARGET_W  = 31;
  localparam int ROOT_W    = 26;
  localparam int INT_STEPS = 16;

  typedef logic [1:0] state_t;

endpackage

>>> rtl/bisection_square_root.sv
// A target word is accepted in IDLE, then RUN settles the decision bits of the
// root from the top bit down. One decision bit is settled per cycle by a single
// shared squarer and compare against target scaled by 2^(2*FRAC_STEPS).
// The root word is then held valid in DONE until root_ready;
// the block takes no new target until the pending root is taken.
// Reset: synchronous, active high; returns to idle and drops root_valid.
module bisection_square_root
  import bsr_pkg::*;
#(
  parameter int FRAC_STEPS  = 10,
  parameter int TARGET_BITS = 31
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                target_valid,
  output logic                target_ready,
  input  logic [TARGET_W-1:0] target,
  output logic                root_valid,
  input  logic                root_ready,
  output logic [ROOT_W-1:0]   root
);

  localparam int OPW  = INT_STEPS + FRAC_STEPS;
  localparam int PW   = $clog2(OPW);
  localparam int TW   = (TARGET_BITS < TARGET_W) ? TARGET_BITS : TARGET_W;
  localparam int SUMW = (OPW + 1 > ROOT_W) ? OPW + 1 : ROOT_W;

  localparam state_t IDLE = 2'd0;
  localparam state_t RUN  = 2'd1;
  localparam state_t DONE = 2'd2;

  state_t              state;
  logic [PW-1:0]       pos;
  logic [OPW-1:0]      left;
  logic [TW-1:0]       t;
  logic [OPW-1:0]      op;
  logic [2*OPW-1:0]    prod;
  logic [2*OPW-1:0]    goal;
  logic                lt;
  logic [OPW-1:0]      left_next;
  logic [SUMW-1:0]     sum;

  assign op        = left | (OPW'(1) << pos);
  assign prod      = op * op;
  assign goal      = (2*OPW)'(t) << (2 * FRAC_STEPS);
  assign lt        = prod < goal;
  assign left_next = lt ? op : left;
  assign sum       = SUMW'(left_next) + SUMW'(lt);

  assign target_ready = (state == IDLE);
  assign root_valid   = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pos   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (target_valid) begin
            t     <= target[TW-1:0];
            left  <= '0;
            pos   <= PW'(OPW - 1);
            state <= RUN;
          end
        end
        RUN: begin
          left <= left_next;
          if (pos == '0) begin
            root  <= sum[ROOT_W-1:0];
            state <= DONE;
          end else begin
            pos <= pos - 1'b1;
          end
        end
        DONE: begin
          if (root_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/bsr_checker.sv
module bsr_checker
  import bsr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                target_valid,
  input logic                target_ready,
  input logic [TARGET_W-1:0] target,
  input logic                root_valid,
  input logic                root_ready,
  input logic [ROOT_W-1:0]   root
);

  a_root_hold: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |=> root_valid && $stable(root))
    else $error("root word dropped or changed while stalled");

  a_target_hold: assert property (@(posedge clk) disable iff (rst)
    target_valid && !target_ready |=> target_valid && $stable(target))
    else $error("target word dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    target_valid && target_ready |=> !target_ready && !root_valid)
    else $error("block not busy after taking a target word");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(target_ready && root_valid))
    else $error("ready for target while root pending");

  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    root_valid && root_ready |=> target_ready && !root_valid)
    else $error("block not idle after root taken");

endmodule

bind bisection_square_root bsr_checker u_bsr_checker (.*);
